[rtl/tlut_pkg.sv]
// ----------------------------------------------------------------------------
// tlut_pkg
// Shared types and constants for the tool life usage table: command codes,
// fault codes, field widths, controller states and the control bundles.
// ----------------------------------------------------------------------------
package tlut_pkg;

	localparam int TIME_W    = 32;
	localparam int FAULT_W   = 8;
	localparam int PCT_W     = 16;
	localparam int IDX_W     = 3;
	localparam int CMD_W     = 3;
	localparam int SCALE_W   = 7;
	localparam int PROD_W    = TIME_W + SCALE_W;
	localparam int WIDE_W    = TIME_W + PCT_W;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int SWEEP_LAST_DEF = 6;

	localparam logic [SCALE_W-1:0] PERCENT_SCALE = SCALE_W'(100);
	localparam logic [FAULT_W-1:0] CODE_NONE     = FAULT_W'(0);
	localparam logic [FAULT_W-1:0] CODE_OVERTIME = FAULT_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 3'd0,
		CMD_SET_USED   = 3'd1,
		CMD_SET_MAX    = 3'd2,
		CMD_RESET      = 3'd3,
		CMD_SET_FAULT  = 3'd4,
		CMD_SET_ENABLE = 3'd5,
		CMD_QUERY      = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SWEEP,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic apply;
		logic sweep;
		logic mul;
		logic div_start;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic is_enable;
		logic sweep_done;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

[rtl/tlut_div.sv]
// ----------------------------------------------------------------------------
// tlut_div
// Serial restoring divider for the usage percentage: one quotient bit per
// cycle, with the saturation case settled by one compare at start.
// ----------------------------------------------------------------------------
module tlut_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tlut_pkg::PROD_W-1:0] dividend,
	input  logic [tlut_pkg::TIME_W-1:0] divisor,
	output logic [tlut_pkg::PCT_W-1:0]  quotient,
	output logic                        done
);

	localparam int CNT_W = $clog2(tlut_pkg::PCT_W);

	logic [tlut_pkg::TIME_W-1:0] rem_q;
	logic [tlut_pkg::PCT_W-1:0]  low_q;
	logic [tlut_pkg::PCT_W-1:0]  quot_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        sat;
	logic [tlut_pkg::TIME_W:0]   trial;
	logic [tlut_pkg::TIME_W:0]   diff;
	logic                        ge;

	// quotient beyond the output range when dividend >= divisor * 2^16
	assign sat = tlut_pkg::WIDE_W'(dividend) >= {divisor, {tlut_pkg::PCT_W{1'b0}}};

	assign trial = {rem_q, low_q[tlut_pkg::PCT_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// top part of the dividend is already below the divisor
			rem_q  <= tlut_pkg::TIME_W'(dividend >> tlut_pkg::PCT_W);
			low_q  <= dividend[tlut_pkg::PCT_W-1:0];
			quot_q <= sat ? '1 : '0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[tlut_pkg::TIME_W-1:0] : trial[tlut_pkg::TIME_W-1:0];
			low_q  <= {low_q[tlut_pkg::PCT_W-2:0], 1'b0};
			quot_q <= {quot_q[tlut_pkg::PCT_W-2:0], ge};
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

[rtl/tlut_datapath.sv]
// ----------------------------------------------------------------------------
// tlut_datapath
// Slot storage, command update logic, enable sweep, percent multiplier and
// divider, and the result register.
// ----------------------------------------------------------------------------
module tlut_datapath #(
	parameter int SLOT_COUNT = tlut_pkg::SLOT_COUNT_DEF,
	parameter int SWEEP_LAST = tlut_pkg::SWEEP_LAST_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlut_pkg::ctrl_t              ctrl,
	output tlut_pkg::stat_t              stat,
	input  logic [tlut_pkg::CMD_W-1:0]   command,
	input  logic [tlut_pkg::IDX_W-1:0]   tool_index,
	input  logic [tlut_pkg::TIME_W-1:0]  operand_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tlut_pkg::TIME_W-1:0]  used_time,
	output logic [tlut_pkg::TIME_W-1:0]  limit_time,
	output logic [tlut_pkg::PCT_W-1:0]   usage_percent,
	output logic [tlut_pkg::FAULT_W-1:0] fault_code,
	output logic                         over_limit,
	output logic                         pickable,
	output logic                         tracking_on
);

	// only slots reachable through the index field are kept
	localparam int IDX_SPAN   = 1 << tlut_pkg::IDX_W;
	localparam int SLOT_STORE = (SLOT_COUNT < IDX_SPAN) ? SLOT_COUNT : IDX_SPAN;
	localparam int AW         = $clog2(SLOT_STORE);
	localparam int SWEEP_END  = (SWEEP_LAST < SLOT_STORE - 1) ? SWEEP_LAST : SLOT_STORE - 1;

	logic [tlut_pkg::TIME_W-1:0]  used_q  [SLOT_STORE];
	logic [tlut_pkg::TIME_W-1:0]  limit_q [SLOT_STORE];
	logic [tlut_pkg::FAULT_W-1:0] fault_q [SLOT_STORE];
	logic                         track_q;
	logic [AW-1:0]                sweep_q;

	tlut_pkg::cmd_t               cmd_q;
	logic [tlut_pkg::IDX_W-1:0]   idx_q;
	logic [tlut_pkg::TIME_W-1:0]  val_q;

	logic [tlut_pkg::PROD_W-1:0]  product_q;
	logic [tlut_pkg::TIME_W-1:0]  snap_used_q;
	logic [tlut_pkg::TIME_W-1:0]  snap_limit_q;
	logic [tlut_pkg::FAULT_W-1:0] snap_fault_q;
	logic                         snap_ok_q;
	logic                         out_valid_q;

	logic [AW-1:0]                slot_a;
	logic                         ok;
	logic [tlut_pkg::TIME_W-1:0]  rd_used;
	logic [tlut_pkg::TIME_W-1:0]  rd_limit;
	logic [tlut_pkg::FAULT_W-1:0] rd_fault;
	logic [tlut_pkg::TIME_W:0]    sum;
	logic [tlut_pkg::TIME_W-1:0]  upd_used;
	logic [tlut_pkg::TIME_W-1:0]  upd_limit;
	logic [tlut_pkg::FAULT_W-1:0] upd_fault;
	logic [tlut_pkg::FAULT_W-1:0] sw_fault;
	logic [tlut_pkg::PCT_W-1:0]   quotient;
	logic                         div_done;

	assign slot_a   = idx_q[AW-1:0];
	assign ok       = 32'(idx_q) < 32'(SLOT_COUNT);
	assign rd_used  = used_q[slot_a];
	assign rd_limit = limit_q[slot_a];
	assign rd_fault = fault_q[slot_a];
	assign sum      = {1'b0, rd_used} + {1'b0, val_q};

	always_comb begin
		upd_used  = rd_used;
		upd_limit = rd_limit;
		upd_fault = rd_fault;
		case (cmd_q)
			tlut_pkg::CMD_ADD: begin
				upd_used = sum[tlut_pkg::TIME_W] ? '1 : sum[tlut_pkg::TIME_W-1:0];
			end
			tlut_pkg::CMD_SET_USED: begin
				upd_used = val_q;
				if (rd_fault == tlut_pkg::CODE_OVERTIME && val_q < rd_limit) begin
					upd_fault = tlut_pkg::CODE_NONE;
				end
			end
			tlut_pkg::CMD_SET_MAX: begin
				upd_limit = val_q;
				if (rd_used >= val_q) begin
					if (rd_fault == tlut_pkg::CODE_NONE && track_q) begin
						upd_fault = tlut_pkg::CODE_OVERTIME;
					end
				end else if (rd_fault == tlut_pkg::CODE_OVERTIME) begin
					upd_fault = tlut_pkg::CODE_NONE;
				end
			end
			tlut_pkg::CMD_RESET: begin
				upd_used  = '0;
				upd_fault = tlut_pkg::CODE_NONE;
			end
			tlut_pkg::CMD_SET_FAULT: begin
				upd_fault = val_q[tlut_pkg::FAULT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// one slot of the enable sweep per cycle
	always_comb begin
		sw_fault = fault_q[sweep_q];
		if (track_q) begin
			if (fault_q[sweep_q] == tlut_pkg::CODE_NONE &&
			    used_q[sweep_q] >= limit_q[sweep_q]) begin
				sw_fault = tlut_pkg::CODE_OVERTIME;
			end
		end else if (fault_q[sweep_q] == tlut_pkg::CODE_OVERTIME) begin
			sw_fault = tlut_pkg::CODE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_STORE; i++) begin
				used_q[i]  <= '0;
				limit_q[i] <= '0;
				fault_q[i] <= tlut_pkg::CODE_NONE;
			end
			track_q <= 1'b1;
			sweep_q <= '0;
		end else begin
			if (ctrl.apply) begin
				if (cmd_q == tlut_pkg::CMD_SET_ENABLE) begin
					track_q <= val_q[0];
				end else if (ok) begin
					used_q[slot_a]  <= upd_used;
					limit_q[slot_a] <= upd_limit;
					fault_q[slot_a] <= upd_fault;
				end
				sweep_q <= AW'(1);
			end
			if (ctrl.sweep) begin
				fault_q[sweep_q] <= sw_fault;
				sweep_q          <= sweep_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			cmd_q <= tlut_pkg::cmd_t'(command);
			idx_q <= tool_index;
			val_q <= operand_value;
		end
		if (ctrl.mul) begin
			product_q    <= tlut_pkg::PROD_W'(rd_used) * tlut_pkg::PROD_W'(tlut_pkg::PERCENT_SCALE);
			snap_used_q  <= rd_used;
			snap_limit_q <= rd_limit;
			snap_fault_q <= rd_fault;
			snap_ok_q    <= ok;
		end
	end

	tlut_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (product_q),
		.divisor  (snap_limit_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			tracking_on <= track_q;
			if (snap_ok_q) begin
				used_time     <= snap_used_q;
				limit_time    <= snap_limit_q;
				usage_percent <= (snap_limit_q == '0) ? '0 : quotient;
				fault_code    <= snap_fault_q;
				over_limit    <= track_q && (snap_used_q > snap_limit_q);
				pickable      <= (snap_fault_q == tlut_pkg::CODE_NONE) ||
				                 (snap_fault_q == tlut_pkg::CODE_OVERTIME);
			end else begin
				used_time     <= '0;
				limit_time    <= '0;
				usage_percent <= '0;
				fault_code    <= '0;
				over_limit    <= 1'b0;
				pickable      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign stat.is_enable  = (cmd_q == tlut_pkg::CMD_SET_ENABLE);
	assign stat.sweep_done = (sweep_q == AW'(SWEEP_END));
	assign stat.div_done   = div_done;
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

[rtl/tlut_ctrl.sv]
// ----------------------------------------------------------------------------
// tlut_ctrl
// Controller state machine: sequences command apply, enable sweep,
// percent multiply and divide, and result hand-off.
// ----------------------------------------------------------------------------
module tlut_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tlut_pkg::stat_t stat,
	output tlut_pkg::ctrl_t ctrl
);

	tlut_pkg::state_t state_q;
	tlut_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlut_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tlut_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = tlut_pkg::ST_APPLY;
			end
			tlut_pkg::ST_APPLY: begin
				state_nxt = stat.is_enable ? tlut_pkg::ST_SWEEP : tlut_pkg::ST_MUL;
			end
			tlut_pkg::ST_SWEEP: begin
				if (stat.sweep_done) state_nxt = tlut_pkg::ST_MUL;
			end
			tlut_pkg::ST_MUL: begin
				state_nxt = tlut_pkg::ST_DIV_START;
			end
			tlut_pkg::ST_DIV_START: begin
				state_nxt = tlut_pkg::ST_DIV_WAIT;
			end
			tlut_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) state_nxt = tlut_pkg::ST_EMIT;
			end
			tlut_pkg::ST_EMIT: begin
				if (stat.out_free) state_nxt = tlut_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = tlut_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tlut_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.take = in_valid;
			end
			tlut_pkg::ST_APPLY:     ctrl.apply     = 1'b1;
			tlut_pkg::ST_SWEEP:     ctrl.sweep     = 1'b1;
			tlut_pkg::ST_MUL:       ctrl.mul       = 1'b1;
			tlut_pkg::ST_DIV_START: ctrl.div_start = 1'b1;
			tlut_pkg::ST_DIV_WAIT: begin
			end
			tlut_pkg::ST_EMIT:      ctrl.emit      = stat.out_free;
			default: begin
			end
		endcase
	end

endmodule

[rtl/tool_life_usage_table.sv]
// ----------------------------------------------------------------------------
// tool_life_usage_table
// Tool slot table of used time, limit time and fault code with a global
// tracking flag; each command reports one slot after it is applied.
//
//   channel  signals                                     direction
//   in       in_valid/in_ready, command, tool_index,     into block
//            operand_value
//   out      out_valid/out_ready, used_time, limit_time, out of block
//            usage_percent, fault_code, over_limit,
//            pickable, tracking_on
//
// One transaction at a time, in order: apply, enable sweep (1 cycle per swept
// slot), multiply, divider start, divider wait (done at start when the
// percentage saturates or the limit is zero, else one quotient bit a cycle)
// and hand-off, where out_valid rises; the controller then returns to idle
// to accept the next command.
// A result waiting in the output register does not stop the next accept;
// the block stalls in hand-off only when the output register is still full.
// Reset clears all slots and sets tracking on; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tool_life_usage_table #(
	parameter int SLOT_COUNT = tlut_pkg::SLOT_COUNT_DEF,
	parameter int SWEEP_LAST = tlut_pkg::SWEEP_LAST_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tlut_pkg::CMD_W-1:0]   command,
	input  logic [tlut_pkg::IDX_W-1:0]   tool_index,
	input  logic [tlut_pkg::TIME_W-1:0]  operand_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tlut_pkg::TIME_W-1:0]  used_time,
	output logic [tlut_pkg::TIME_W-1:0]  limit_time,
	output logic [tlut_pkg::PCT_W-1:0]   usage_percent,
	output logic [tlut_pkg::FAULT_W-1:0] fault_code,
	output logic                         over_limit,
	output logic                         pickable,
	output logic                         tracking_on
);

	tlut_pkg::ctrl_t ctrl;
	tlut_pkg::stat_t stat;

	tlut_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	tlut_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.SWEEP_LAST (SWEEP_LAST)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.command       (command),
		.tool_index    (tool_index),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.used_time     (used_time),
		.limit_time    (limit_time),
		.usage_percent (usage_percent),
		.fault_code    (fault_code),
		.over_limit    (over_limit),
		.pickable      (pickable),
		.tracking_on   (tracking_on)
	);

endmodule

[tb/tb_tool_life_usage_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tool_life_usage_table
// Self-checking bench for the tool life usage table. A scoreboard class keeps
// its own copy of the slot table and the tracking flag, predicts one report
// per accepted command and checks every report the block hands out. A short
// directed run covers the corner cases, then random commands run through
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

typedef struct {
	logic [tlut_pkg::TIME_W-1:0]  used;
	logic [tlut_pkg::TIME_W-1:0]  limit;
	logic [tlut_pkg::PCT_W-1:0]   pct;
	logic [tlut_pkg::FAULT_W-1:0] fault;
	logic                         over;
	logic                         pick;
	logic                         track;
} slot_report_t;

class usage_scoreboard;
	localparam int SLOTS = tlut_pkg::SLOT_COUNT_DEF;
	localparam int SWEEP_TOP = tlut_pkg::SWEEP_LAST_DEF;
	localparam logic [63:0] PCT_CEIL = 64'd65535;

	logic [tlut_pkg::TIME_W-1:0]  used_tab  [SLOTS];
	logic [tlut_pkg::TIME_W-1:0]  limit_tab [SLOTS];
	logic [tlut_pkg::FAULT_W-1:0] fault_tab [SLOTS];
	logic                         track_en;
	slot_report_t                 expected_reports [$];
	int                           error_count;

	function new();
		for (int k = 0; k < SLOTS; k++) begin
			used_tab[k]  = '0;
			limit_tab[k] = '0;
			fault_tab[k] = tlut_pkg::CODE_NONE;
		end
		track_en    = 1'b1;
		error_count = 0;
	endfunction

	function void mark_overtime(int s);
		if (fault_tab[s] == tlut_pkg::CODE_NONE && track_en && used_tab[s] >= limit_tab[s])
			fault_tab[s] = tlut_pkg::CODE_OVERTIME;
	endfunction

	function void lift_overtime(int s);
		if (fault_tab[s] == tlut_pkg::CODE_OVERTIME && used_tab[s] < limit_tab[s])
			fault_tab[s] = tlut_pkg::CODE_NONE;
	endfunction

	function int pending();
		return expected_reports.size();
	endfunction

	// apply one accepted command to the local table and queue its report
	function void note_command(logic [2:0] cmd, logic [2:0] idx, logic [31:0] val);
		int s;
		logic [32:0] sum;
		logic [63:0] prod;
		logic [63:0] quo;
		slot_report_t r;
		s = int'(idx);
		if (cmd == tlut_pkg::CMD_SET_ENABLE) begin
			track_en = val[0];
			for (int k = 1; k <= SWEEP_TOP && k < SLOTS; k++) begin
				if (track_en)
					mark_overtime(k);
				else if (fault_tab[k] == tlut_pkg::CODE_OVERTIME)
					fault_tab[k] = tlut_pkg::CODE_NONE;
			end
		end else begin
			case (cmd)
				tlut_pkg::CMD_ADD: begin
					sum = {1'b0, used_tab[s]} + {1'b0, val};
					used_tab[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
				tlut_pkg::CMD_SET_USED: begin
					used_tab[s] = val;
					lift_overtime(s);
				end
				tlut_pkg::CMD_SET_MAX: begin
					limit_tab[s] = val;
					mark_overtime(s);
					lift_overtime(s);
				end
				tlut_pkg::CMD_RESET: begin
					used_tab[s]  = '0;
					fault_tab[s] = tlut_pkg::CODE_NONE;
				end
				tlut_pkg::CMD_SET_FAULT: fault_tab[s] = val[7:0];
				default: ;
			endcase
		end
		quo = '0;
		if (limit_tab[s] != 0) begin
			prod = {32'b0, used_tab[s]} * 64'(tlut_pkg::PERCENT_SCALE);
			quo  = prod / {32'b0, limit_tab[s]};
			if (quo > PCT_CEIL)
				quo = PCT_CEIL;
		end
		r.used  = used_tab[s];
		r.limit = limit_tab[s];
		r.pct   = quo[15:0];
		r.fault = fault_tab[s];
		r.over  = track_en && (used_tab[s] > limit_tab[s]);
		r.pick  = (fault_tab[s] == tlut_pkg::CODE_NONE) ||
			(fault_tab[s] == tlut_pkg::CODE_OVERTIME);
		r.track = track_en;
		expected_reports.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	function void check_report(slot_report_t got);
		slot_report_t want;
		if (expected_reports.size() == 0) begin
			$error("report with no command outstanding");
			error_count++;
			return;
		end
		want = expected_reports.pop_front();
		compare_field("used_time", want.used, got.used);
		compare_field("limit_time", want.limit, got.limit);
		compare_field("usage_percent", 32'(want.pct), 32'(got.pct));
		compare_field("fault_code", 32'(want.fault), 32'(got.fault));
		compare_field("over_limit", 32'(want.over), 32'(got.over));
		compare_field("pickable", 32'(want.pick), 32'(got.pick));
		compare_field("tracking_on", 32'(want.track), 32'(got.track));
	endfunction
endclass

module tb_tool_life_usage_table;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 113;
	localparam logic [2:0] CMD_SPARE = 3'd7;   // undefined code, acts as query

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [tlut_pkg::CMD_W-1:0]    command = '0;
	logic [tlut_pkg::IDX_W-1:0]    tool_index = '0;
	logic [tlut_pkg::TIME_W-1:0]   operand_value = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [tlut_pkg::TIME_W-1:0]   used_time;
	logic [tlut_pkg::TIME_W-1:0]   limit_time;
	logic [tlut_pkg::PCT_W-1:0]    usage_percent;
	logic [tlut_pkg::FAULT_W-1:0]  fault_code;
	logic                          over_limit;
	logic                          pickable;
	logic                          tracking_on;

	usage_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	tool_life_usage_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.tool_index    (tool_index),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.used_time     (used_time),
		.limit_time    (limit_time),
		.usage_percent (usage_percent),
		.fault_code    (fault_code),
		.over_limit    (over_limit),
		.pickable      (pickable),
		.tracking_on   (tracking_on)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[tool_life_usage_table] ERROR");
			$finish;
		end
	end

	// result side: check each transaction, then pick the next ready value
	always @(posedge clk) begin
		slot_report_t got;
		if (arst_n && out_valid && out_ready) begin
			got.used  = used_time;
			got.limit = limit_time;
			got.pct   = usage_percent;
			got.fault = fault_code;
			got.over  = over_limit;
			got.pick  = pickable;
			got.track = tracking_on;
			sb.check_report(got);
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_command(input logic [2:0] cmd, input logic [2:0] idx,
			input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		tool_index    <= idx;
		operand_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_command(cmd, idx, val);
	endtask

	// hold off the sender until every outstanding report is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_time();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return $urandom_range(300);
		if (roll < 55)
			return 32'hFFFF_FFFF - $urandom_range(3);
		if (roll < 60)
			return 32'h0;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_fault();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return {24'($urandom_range(16777215)), tlut_pkg::CODE_NONE};
		if (roll < 65)
			return {24'($urandom_range(16777215)), tlut_pkg::CODE_OVERTIME};
		return $urandom;
	endfunction

	task automatic run_random(input int count);
		int roll;
		logic [2:0] cmd;
		logic [31:0] val;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 20)      cmd = tlut_pkg::CMD_ADD;
			else if (roll < 32) cmd = tlut_pkg::CMD_SET_USED;
			else if (roll < 47) cmd = tlut_pkg::CMD_SET_MAX;
			else if (roll < 55) cmd = tlut_pkg::CMD_RESET;
			else if (roll < 65) cmd = tlut_pkg::CMD_SET_FAULT;
			else if (roll < 75) cmd = tlut_pkg::CMD_SET_ENABLE;
			else if (roll < 95) cmd = tlut_pkg::CMD_QUERY;
			else                cmd = CMD_SPARE;
			case (cmd)
				tlut_pkg::CMD_ADD:
					val = ($urandom_range(9) == 0) ? $urandom : $urandom_range(100);
				tlut_pkg::CMD_SET_USED,
				tlut_pkg::CMD_SET_MAX:    val = pick_time();
				tlut_pkg::CMD_SET_FAULT:  val = pick_fault();
				// mostly keep tracking on so overtime builds up
				tlut_pkg::CMD_SET_ENABLE:
					val = {31'($urandom), 1'b0} | 32'($urandom_range(99) < 65);
				default:                  val = $urandom;
			endcase
			send_command(cmd, 3'($urandom_range(7)), val);
		end
	endtask

	initial begin
		int idle_tab [4];
		int stall_tab [4];
		idle_tab  = '{0, 67, 0, 33};
		stall_tab = '{0, 0, 67, 33};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases
		send_command(tlut_pkg::CMD_QUERY, 3'd0, 32'h0);  // reset state, zero limit
		send_command(tlut_pkg::CMD_SET_MAX, 3'd1, 32'd100);
		send_command(tlut_pkg::CMD_ADD, 3'd1, 32'd50);
		send_command(tlut_pkg::CMD_ADD, 3'd1, 32'd60);  // over limit, code untouched
		send_command(tlut_pkg::CMD_SET_ENABLE, 3'd0, 32'h1);  // sweep raises slot 1
		send_command(tlut_pkg::CMD_QUERY, 3'd1, 32'h0);
		send_command(tlut_pkg::CMD_SET_USED, 3'd1, 32'd20);  // clears overtime
		send_command(tlut_pkg::CMD_SET_MAX, 3'd2, 32'h0);  // used equals max, raise
		send_command(tlut_pkg::CMD_ADD, 3'd3, 32'hFFFF_FFFF);
		send_command(tlut_pkg::CMD_ADD, 3'd3, 32'd5);  // saturating add
		send_command(tlut_pkg::CMD_SET_MAX, 3'd3, 32'd1);  // percent saturates
		send_command(tlut_pkg::CMD_SET_FAULT, 3'd4, 32'hFFFF_FF07);
		send_command(tlut_pkg::CMD_SET_FAULT, 3'd5, 32'h0000_0001);  // host-written overtime
		send_command(tlut_pkg::CMD_SET_MAX, 3'd7, 32'd10);
		send_command(tlut_pkg::CMD_ADD, 3'd7, 32'd20);
		send_command(tlut_pkg::CMD_SET_ENABLE, 3'd7, 32'hFFFF_FFFE);  // tracking off clears
		send_command(tlut_pkg::CMD_QUERY, 3'd3, 32'hFFFF_FFFF);
		send_command(tlut_pkg::CMD_SET_MAX, 3'd0, 32'h0);  // no raise with tracking off
		send_command(tlut_pkg::CMD_SET_ENABLE, 3'd2, 32'hFFFF_FFFF);  // slots 0, 7 not swept
		send_command(tlut_pkg::CMD_QUERY, 3'd7, 32'h0);
		send_command(tlut_pkg::CMD_RESET, 3'd3, 32'hFFFF_FFFF);  // keeps max
		send_command(CMD_SPARE, 3'd3, 32'hA5A5_A5A5);
		send_command(tlut_pkg::CMD_SET_MAX, 3'd6, 32'hFFFF_FFFF);
		send_command(tlut_pkg::CMD_SET_USED, 3'd6, 32'hFFFF_FFFF);
		send_command(tlut_pkg::CMD_SET_USED, 3'd2, 32'h0);  // used equals max, code stays
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_tab[p];
			recv_stall_pct = stall_tab[p];
			run_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d reports never arrived", sb.pending());
			sb.error_count++;
		end
		if (sb.error_count == 0)
			$display("[tool_life_usage_table] OK");
		else
			$display("[tool_life_usage_table] ERROR");
		$finish;
	end

endmodule
